// ----- src/assert_macros.svh -----
// Assertion macros used by the top RTL file of the decimal display driver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/dss_pkg.sv -----
// Types, constants and the segment font of the decimal display driver.
`default_nettype none

package dss_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int NUM_STAGES = 7;

    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [13:0] RECIP_THOUSAND = 14'd8389;
    localparam logic [14:0] SAT_MAX = 15'd9999;

    typedef logic [1:0] t_pos;
    typedef logic [7:0] t_seg;

    typedef struct packed {
        t_seg [NUM_DIGITS-1:0] pat;
    } t_digits;

    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
        logic [4:0]  thou;
        logic [9:0]  rest;
        logic [3:0]  hund;
        logic [6:0]  rem;
        logic [3:0]  tens;
        logic [3:0]  ones;
    } t_work;

    function automatic t_seg seg_font(input logic [3:0] d);
        t_seg p;
        case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7C;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h67;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- src/dss_split.sv -----
// Pipelined split of a value into its sign and decimal digit patterns.
`default_nettype none

module dss_split
    import dss_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_enable,
    input  wire logic [14:0]   i_value,
    output      logic          o_ready,
    output      logic          o_dig_valid,
    output      t_digits       o_digits,
    input  wire logic          i_take
);

    logic [NUM_STAGES-1:0] r_valid;
    t_work                 r_work [NUM_STAGES];
    t_work                 n_work [NUM_STAGES];
    logic [NUM_STAGES:0]   w_rdy;

    logic [15:0] w_neg_mag;
    logic [28:0] w_prod_thou;
    logic [14:0] w_sub_thou;
    logic [15:0] w_prod_hund;
    logic [9:0]  w_sub_hund;
    logic [14:0] w_prod_tens;
    logic [6:0]  w_sub_tens;

    always_comb begin
        w_rdy[NUM_STAGES] = i_take;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_valid[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];

    assign w_neg_mag   = 16'h8000 - {1'b0, i_value};
    assign w_prod_thou = {14'd0, r_work[0].mag} * {15'd0, RECIP_THOUSAND};
    assign w_sub_thou  = r_work[1].mag - ({10'd0, r_work[1].thou} * 15'd1000);
    assign w_prod_hund = {6'd0, r_work[2].rest} * 16'd41;
    assign w_sub_hund  = r_work[3].rest - ({6'd0, r_work[3].hund} * 10'd100);
    assign w_prod_tens = {8'd0, r_work[4].rem} * 15'd205;
    assign w_sub_tens  = r_work[5].rem - ({3'd0, r_work[5].tens} * 7'd10);

    always_comb begin
        n_work[0]      = '0;
        n_work[0].neg  = i_value[14];
        if (i_value[14]) begin
            n_work[0].mag = w_neg_mag[14:0];
        end else if (i_value > SAT_MAX) begin
            n_work[0].mag = SAT_MAX;
        end else begin
            n_work[0].mag = i_value;
        end

        n_work[1]      = r_work[0];
        n_work[1].thou = w_prod_thou[27:23];

        n_work[2]      = r_work[1];
        n_work[2].rest = w_sub_thou[9:0];

        n_work[3]      = r_work[2];
        n_work[3].hund = w_prod_hund[15:12];

        n_work[4]      = r_work[3];
        n_work[4].rem  = w_sub_hund[6:0];

        n_work[5]      = r_work[4];
        n_work[5].tens = w_prod_tens[14:11];

        n_work[6]      = r_work[5];
        n_work[6].ones = w_sub_tens[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_valid[0] <= i_valid && i_enable;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_work[k] <= n_work[k];
            end
        end
    end

    assign o_dig_valid = r_valid[NUM_STAGES-1];

    always_comb begin
        o_digits.pat[0] = r_work[NUM_STAGES-1].neg ? SEG_MINUS
                                                   : seg_font(r_work[NUM_STAGES-1].thou[3:0]);
        o_digits.pat[1] = seg_font(r_work[NUM_STAGES-1].hund);
        o_digits.pat[2] = seg_font(r_work[NUM_STAGES-1].tens);
        o_digits.pat[3] = seg_font(r_work[NUM_STAGES-1].ones);
    end

endmodule

`default_nettype wire

// ----- src/dss_scan.sv -----
// Output register that sends the four digit patterns of one value in order.
`default_nettype none

module dss_scan
    import dss_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_dig_valid,
    input  wire t_digits i_digits,
    output      logic    o_take,
    output      logic    o_valid,
    input  wire logic    i_ready,
    output      t_pos    o_digit_position,
    output      t_seg    o_segment_pattern,
    output      logic    o_last_digit
);

    localparam t_pos LAST_POS = t_pos'(NUM_DIGITS - 1);

    logic    r_full;
    t_pos    r_pos;
    t_digits r_digits;

    assign o_last_digit      = (r_pos == LAST_POS);
    assign o_take            = !r_full || (i_ready && o_last_digit);
    assign o_valid           = r_full;
    assign o_digit_position  = r_pos;
    assign o_segment_pattern = r_digits.pat[r_pos];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_pos  <= '0;
        end else if (o_take) begin
            r_full <= i_dig_valid;
            r_pos  <= '0;
        end else if (i_ready) begin
            r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_digits <= i_digits;
        end
    end

endmodule

`default_nettype wire

// ----- src/decimal_seven_segment_scan.sv -----
// The digits of a value pass through the seven split stages and then the scan register.
// The scan register sends one digit a cycle while i_ready is high, four digits per value;
// the split pipeline takes a request every cycle until it fills.
// Reset is synchronous and active low; it empties the pipeline and turns the display off.
// While the display is off, accepted requests are dropped and give no digits.
`default_nettype none

`include "assert_macros.svh"

module decimal_seven_segment_scan
    import dss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic        i_cfg_display_on,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [14:0] i_value,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [1:0]  o_digit_position,
    output      logic [7:0]  o_segment_pattern,
    output      logic        o_last_digit
);

    logic    r_display_on;
    logic    w_dig_valid;
    t_digits w_digits;
    logic    w_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_on <= 1'b0;
        end else if (i_cfg_valid) begin
            r_display_on <= i_cfg_display_on;
        end
    end

    dss_split u_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_enable    (r_display_on),
        .i_value     (i_value),
        .o_ready     (o_ready),
        .o_dig_valid (w_dig_valid),
        .o_digits    (w_digits),
        .i_take      (w_take)
    );

    dss_scan u_scan (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_dig_valid       (w_dig_valid),
        .i_digits          (w_digits),
        .o_take            (w_take),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_digit_position  (o_digit_position),
        .o_segment_pattern (o_segment_pattern),
        .o_last_digit      (o_last_digit)
    );

    `ASSERT_SAME_CYCLE(a_last_on_pos3, i_clk, i_rst_n, o_valid,
        o_last_digit == (o_digit_position == 2'd3), "last digit flag off position three")
    `ASSERT_NEXT_CYCLE(a_scan_advances, i_clk, i_rst_n, o_valid && i_ready && !o_last_digit,
        o_valid && (o_digit_position == $past(o_digit_position) + 2'd1), "scan skipped a digit")
    `ASSERT_NEXT_CYCLE(a_start_at_zero, i_clk, i_rst_n, o_valid && i_ready && o_last_digit,
        !o_valid || (o_digit_position == 2'd0), "new value did not start at position zero")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the decimal scan driver with random and directed values and a digit scoreboard.
`timescale 1ns / 100ps

module tb;
    import dss_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 16;
    localparam int TAIL_CYCLES = 30;

    localparam t_seg DIGIT_FONT [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7C, 8'h07, 8'h7F, 8'h67
    };

    localparam int BLANKED_VALUES [3] = '{0, 1234, -5};
    localparam int DIRECTED_VALUES [21] = '{
        0, 1, 9, 10, 99, 100, 999, 1000, 1234, 5678, 8090, 9999, 10000, 16383,
        -1, -9, -999, -1000, -9999, -10000, -16384
    };
    localparam int EDGE_VALUES [12] = '{
        0, 9999, -9999, 10000, 16383, -16384, -1, 1, 1000, -1000, 999, -999
    };
    localparam bit PHASE_DISPLAY_ON [4] = '{1'b1, 1'b0, 1'b1, 1'b1};
    localparam int PHASE_ITEMS [4] = '{70, 20, 70, 75};

    typedef struct {
        t_pos pos;
        t_seg seg;
        logic last;
    } t_digit;

    class digit_checker;
        bit display_on;
        t_digit expected_digits[$];
        int errors;

        function new();
            display_on = 1'b0;
            errors = 0;
        endfunction

        function void note_value(logic [14:0] value);
            int unsigned raw;
            int unsigned rest;
            t_seg pat [NUM_DIGITS];
            t_digit d;
            if (!display_on) begin
                return;
            end
            raw = value;
            if (!value[14]) begin
                if (raw > 9999) begin
                    raw = 9999;
                end
                pat[0] = DIGIT_FONT[raw / 1000];
                rest = raw % 1000;
            end else begin
                pat[0] = SEG_MINUS;
                rest = (32768 - raw) % 1000;
            end
            pat[1] = DIGIT_FONT[rest / 100];
            pat[2] = DIGIT_FONT[(rest / 10) % 10];
            pat[3] = DIGIT_FONT[rest % 10];
            for (int k = 0; k < NUM_DIGITS; k++) begin
                d.pos = t_pos'(k);
                d.seg = pat[k];
                d.last = (k == NUM_DIGITS - 1);
                expected_digits.push_back(d);
            end
        endfunction

        function void check_digit(t_pos pos, t_seg seg, logic last);
            t_digit e;
            if (expected_digits.size() == 0) begin
                $error("Unexpected digit: position %0d, pattern %02h", pos, seg);
                errors++;
                return;
            end
            e = expected_digits.pop_front();
            if (pos !== e.pos) begin
                $error("digit_position: expected %0d, actual %0d", e.pos, pos);
                errors++;
            end
            if (seg !== e.seg) begin
                $error("segment_pattern: expected %02h, actual %02h", e.seg, seg);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_digit: expected %0b, actual %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic i_cfg_display_on = 1'b0;
    logic i_valid = 1'b0;
    logic [14:0] i_value = '0;
    logic i_ready = 1'b0;
    logic o_cfg_ready;
    logic o_ready;
    logic o_valid;
    logic [1:0] o_digit_position;
    logic [7:0] o_segment_pattern;
    logic o_last_digit;

    digit_checker sb;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int idle_cycles = 0;

    decimal_seven_segment_scan u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_display_on  (i_cfg_display_on),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_value           (i_value),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_digit_position  (o_digit_position),
        .o_segment_pattern (o_segment_pattern),
        .o_last_digit      (o_last_digit)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [14:0] random_value();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            v = int'($urandom_range(0, 19998)) - 9999;
        end else if (sel < 70) begin
            v = $urandom_range(0, 32767);
        end else if (sel < 85) begin
            v = EDGE_VALUES[$urandom_range(0, 11)];
        end else begin
            v = int'($urandom_range(0, 198)) - 99;
        end
        return v[14:0];
    endfunction

    task automatic send_value(input logic [14:0] value);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        sb.note_value(value);
    endtask

    task automatic wait_digits_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_digits.size() != 0);
    endtask

    task automatic write_display(input bit on);
        wait_digits_drained();
        // Requests dropped while the display is off may still be in the pipeline.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_display_on <= on;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.display_on = on;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        forever begin
            if (rx_idle && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_digit(o_digit_position, o_segment_pattern, o_last_digit);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (BLANKED_VALUES[n]) begin
            send_value(BLANKED_VALUES[n][14:0]);
        end
        write_display(1'b1);
        foreach (DIRECTED_VALUES[n]) begin
            send_value(DIRECTED_VALUES[n][14:0]);
        end

        for (int p = 0; p < 4; p++) begin
            write_display(PHASE_DISPLAY_ON[p]);
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                if (p == 2 && n == 40) begin
                    wait_digits_drained();
                end
                if (p == 3 && n == 30) begin
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end
                send_value(random_value());
            end
        end

        wait_digits_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.expected_digits.size() != 0) begin
            $error("%0d expected digits never arrived", sb.expected_digits.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
